[src/tty_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tty_pkg
// Shared types and constants of the text terminal tile writer.
// ----------------------------------------------------------------------------
package tty_pkg;
   localparam int SCREEN_COLS = 40;
   localparam int SCREEN_ROWS = 25;

   localparam logic [3:0] ACT_PUT     = 4'd0;
   localparam logic [3:0] ACT_SET     = 4'd1;
   localparam logic [3:0] ACT_SAVE    = 4'd2;
   localparam logic [3:0] ACT_RESTORE = 4'd3;
   localparam logic [3:0] ACT_CLEAR   = 4'd4;
   localparam logic [3:0] ACT_CLR_END = 4'd5;
   localparam logic [3:0] ACT_CLR_EOL = 4'd6;
   localparam logic [3:0] ACT_SCR_UP  = 4'd7;
   localparam logic [3:0] ACT_SCR_DN  = 4'd8;
   localparam logic [3:0] ACT_READ    = 4'd9;

   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_BS  = 8'd8;

   localparam logic [1:0] REG_PALETTE = 2'd0;
   localparam logic [1:0] REG_TOP     = 2'd1;
   localparam logic [1:0] REG_BOTTOM  = 2'd2;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] char_code;
      logic [5:0] col;
      logic [4:0] row;
      logic [4:0] line_count;
   } req_type;

   typedef struct packed {
      logic [5:0] cursor_col_out;
      logic [4:0] cursor_row_out;
      logic [7:0] cell_char;
      logic [4:0] cell_palette;
      logic       scrolled;
   } rsp_type;
endpackage
`default_nettype wire

[src/text_terminal_tile_writer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_terminal_tile_writer_core
// Text terminal over a tile map with cursor, clears, scrolls and cell reads.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its response appears
// on rsp_* for one cycle with rsp_valid and cannot be stalled. Clears walk
// cells one per cycle over a single memory port; scrolls copy each cell
// with a read state, then a write state, and clear one cell per cycle; a
// put char that passes the region's bottom row scrolls it up. After reset a
// clearing pass over all SCREEN_COLS*SCREEN_ROWS cells runs with busy high;
// configuration writes are taken at any time.
module text_terminal_tile_writer_core #(
   parameter int SCREEN_COLS = tty_pkg::SCREEN_COLS,
   parameter int SCREEN_ROWS = tty_pkg::SCREEN_ROWS
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  tty_pkg::req_type req_word,
   output logic             rsp_valid,
   output tty_pkg::rsp_type rsp_word,
   input  wire              csr_valid,
   output logic             csr_ready,
   input  wire  [1:0]       csr_index,
   input  wire  [4:0]       csr_data
);
   localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam int AW = $clog2(CELLS + 1);
   localparam int CW = 6;
   localparam int RW = 5;

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_DO   = 3'd2;
   localparam logic [2:0] ST_CLR  = 3'd3;
   localparam logic [2:0] ST_CPRD = 3'd4;
   localparam logic [2:0] ST_CPWR = 3'd5;
   localparam logic [2:0] ST_RD   = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [7:0] char_mem [CELLS];
   logic [4:0] pal_mem [CELLS];
   logic [7:0] rd_char_ff;
   logic [4:0] rd_pal_ff;

   logic [2:0]    state_ff, state_in;
   tty_pkg::req_type req_ff, req_in;
   logic [CW-1:0] ccol_ff, ccol_in, scol_ff, scol_in;
   logic [RW-1:0] crow_ff, crow_in, srow_ff, srow_in;
   logic [4:0]    pal_ff, top_ff, bot_ff;
   logic [AW-1:0] ptr_ff, ptr_in, end_ff, end_in;
   logic [AW-1:0] cpend_ff, cpend_in;
   logic [AW-1:0] delta_ff, delta_in;
   logic          up_ff, up_in, scr_ff, scr_in;

   logic [4:0] rtop, rbot;
   logic       we, re;
   logic [AW-1:0] waddr, raddr;
   logic [7:0] wchar;
   logic [4:0] wpal;

   always_comb begin
      if (top_ff >= 5'(SCREEN_ROWS) || bot_ff >= 5'(SCREEN_ROWS) || bot_ff < top_ff) begin
         rtop = '0;
         rbot = 5'(SCREEN_ROWS - 1);
      end else begin
         rtop = top_ff;
         rbot = bot_ff;
      end
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_ff <= '0;
         top_ff <= '0;
         bot_ff <= 5'd24;
      end else if (csr_valid) begin
         case (csr_index)
            tty_pkg::REG_PALETTE: pal_ff <= csr_data;
            tty_pkg::REG_TOP:     top_ff <= csr_data;
            tty_pkg::REG_BOTTOM:  bot_ff <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic [AW-1:0] rowbase(input logic [RW-1:0] r);
      rowbase = AW'(r * SCREEN_COLS);
   endfunction

   logic [4:0] h, n;
   logic [7:0] ch;
   logic [CW:0] ncol;
   logic [RW:0] nrow;
   always_comb begin
      state_in = state_ff; req_in = req_ff;
      ccol_in = ccol_ff; crow_in = crow_ff; scol_in = scol_ff; srow_in = srow_ff;
      ptr_in = ptr_ff; end_in = end_ff; cpend_in = cpend_ff; delta_in = delta_ff;
      up_in = up_ff; scr_in = scr_ff;
      we = 1'b0; re = 1'b0; waddr = ptr_ff; raddr = ptr_ff;
      wchar = 8'd0; wpal = pal_ff;
      h = rbot - rtop + 5'd1;
      n = (req_ff.line_count > h) ? h : req_ff.line_count;
      ch = req_ff.char_code;
      ncol = {1'b0, ccol_ff}; nrow = {1'b0, crow_ff};
      case (state_ff)
         ST_INIT: begin
            we = 1'b1; wpal = 5'd0;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == AW'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            scr_in = 1'b0;
            if (start) begin
               req_in = req_word;
               state_in = ST_DO;
            end
         end
         ST_DO: begin
            state_in = ST_DONE;
            case (req_ff.action)
               tty_pkg::ACT_PUT: begin
                  if (ch == tty_pkg::CH_LF) begin
                     ncol = '0; nrow = nrow + 1'b1;
                  end else if (ch == tty_pkg::CH_CR) begin
                     ncol = '0;
                  end else if (ch == tty_pkg::CH_TAB) begin
                     ncol = (ncol + 7'd4) & ~7'd3;
                  end else if (ch == tty_pkg::CH_BS) begin
                     if (ncol != '0) ncol = ncol - 1'b1;
                  end else begin
                     we = 1'b1; waddr = rowbase(crow_ff) + AW'(ccol_ff);
                     wchar = ch;
                     ncol = ncol + 1'b1;
                  end
                  if (ncol >= 7'(SCREEN_COLS)) begin
                     ncol = '0; nrow = nrow + 1'b1;
                  end
                  ccol_in = ncol[CW-1:0];
                  crow_in = nrow[RW-1:0];
                  if (nrow > {1'b0, rbot}) begin
                     crow_in = rbot;
                     scr_in = 1'b1;
                     up_in = 1'b1;
                     delta_in = AW'(SCREEN_COLS);
                     ptr_in = rowbase(rtop);
                     cpend_in = rowbase(rbot);
                     end_in = rowbase(rbot) + AW'(SCREEN_COLS);
                     state_in = (rbot == rtop) ? ST_CLR : ST_CPRD;
                  end
               end
               tty_pkg::ACT_SET: begin
                  if (req_ff.col < CW'(SCREEN_COLS)) ccol_in = req_ff.col;
                  if (req_ff.row < RW'(SCREEN_ROWS)) crow_in = req_ff.row;
               end
               tty_pkg::ACT_SAVE: begin
                  scol_in = ccol_ff; srow_in = crow_ff;
               end
               tty_pkg::ACT_RESTORE: begin
                  ccol_in = scol_ff; crow_in = srow_ff;
               end
               tty_pkg::ACT_CLEAR: begin
                  ccol_in = '0; crow_in = '0;
                  ptr_in = '0; end_in = AW'(CELLS); state_in = ST_CLR;
               end
               tty_pkg::ACT_CLR_END: begin
                  ptr_in = rowbase(crow_ff) + AW'(ccol_ff);
                  end_in = AW'(CELLS); state_in = ST_CLR;
               end
               tty_pkg::ACT_CLR_EOL: begin
                  ptr_in = rowbase(crow_ff) + AW'(ccol_ff);
                  end_in = rowbase(crow_ff) + AW'(SCREEN_COLS); state_in = ST_CLR;
               end
               tty_pkg::ACT_SCR_UP: begin
                  if (n != '0) begin
                     up_in = 1'b1;
                     delta_in = rowbase(n);
                     ptr_in = rowbase(rtop);
                     cpend_in = rowbase(rbot + 5'd1 - n);
                     end_in = rowbase(rbot) + AW'(SCREEN_COLS);
                     state_in = (n == h) ? ST_CLR : ST_CPRD;
                  end
               end
               tty_pkg::ACT_SCR_DN: begin
                  if (n != '0) begin
                     up_in = 1'b0;
                     delta_in = rowbase(n);
                     ptr_in = rowbase(rbot) + AW'(SCREEN_COLS - 1);
                     cpend_in = rowbase(rtop + n);
                     end_in = rowbase(rtop + n);
                     state_in = (n == h) ? ST_CLR : ST_CPRD;
                     if (n == h) begin
                        ptr_in = rowbase(rtop);
                     end
                  end
               end
               tty_pkg::ACT_READ: begin
                  if (req_ff.col < CW'(SCREEN_COLS) && req_ff.row < RW'(SCREEN_ROWS)) begin
                     re = 1'b1;
                     raddr = rowbase(req_ff.row) + AW'(req_ff.col);
                     state_in = ST_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_CPRD: begin
            re = 1'b1;
            raddr = up_ff ? ptr_ff + delta_ff : ptr_ff - delta_ff;
            state_in = ST_CPWR;
         end
         ST_CPWR: begin
            we = 1'b1; wchar = rd_char_ff; wpal = rd_pal_ff;
            state_in = ST_CPRD;
            if (up_ff) begin
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff + 1'b1 == cpend_ff) state_in = ST_CLR;
            end else begin
               ptr_in = ptr_ff - 1'b1;
               if (ptr_ff == cpend_ff) begin
                  state_in = ST_CLR;
                  ptr_in = cpend_ff - delta_ff;
               end
            end
         end
         ST_CLR: begin
            if (ptr_ff < end_ff) begin
               we = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (ptr_ff + 1'b1 >= end_ff) state_in = ST_DONE;
         end
         ST_RD: begin
            state_in = ST_IDLE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         char_mem[waddr] <= wchar;
         pal_mem[waddr] <= wpal;
      end
      if (re) begin
         rd_char_ff <= char_mem[raddr];
         rd_pal_ff <= pal_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ccol_ff <= '0; crow_ff <= '0; scol_ff <= '0; srow_ff <= '0;
         ptr_ff <= '0; scr_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ccol_ff <= ccol_in; crow_ff <= crow_in; scol_ff <= scol_in; srow_ff <= srow_in;
         ptr_ff <= ptr_in; scr_ff <= scr_in;
      end
      req_ff <= req_in; end_ff <= end_in; cpend_ff <= cpend_in;
      delta_ff <= delta_in; up_ff <= up_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE) || (state_ff == ST_RD);
   always_comb begin
      rsp_word.cursor_col_out = ccol_ff;
      rsp_word.cursor_row_out = crow_ff;
      rsp_word.cell_char = (state_ff == ST_RD) ? rd_char_ff : 8'd0;
      rsp_word.cell_palette = (state_ff == ST_RD) ? rd_pal_ff : 5'd0;
      rsp_word.scrolled = scr_ff;
   end

   a_curs_col: assert property (@(posedge clock) disable iff (reset)
      ccol_ff < CW'(SCREEN_COLS)) else $error("cursor column out of range");
   a_curs_row: assert property (@(posedge clock) disable iff (reset)
      crow_ff < RW'(SCREEN_ROWS)) else $error("cursor row out of range");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text terminal tile writer: directed table of
// words, then random traffic with a shadow screen predicting every response.
// ----------------------------------------------------------------------------
module tb;
   localparam int SCREEN_COLS = tty_pkg::SCREEN_COLS;
   localparam int SCREEN_ROWS = tty_pkg::SCREEN_ROWS;
   localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam int LIMIT = 10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tty_pkg::req_type req_word = '0;
   logic rsp_valid;
   tty_pkg::rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [4:0] csr_data = '0;

   always #2 clock = ~clock;

   text_terminal_tile_writer_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow terminal
   logic [7:0] scr_char [CELLS];
   logic [4:0] scr_pal [CELLS];
   int cur_c, cur_r, sav_c, sav_r;
   logic [4:0] pal_sh, top_sh, bot_sh;

   tty_pkg::rsp_type pending_rsp [$];
   int errors = 0;
   int cycles = 0;
   int checked = 0;
   int scrolls_seen = 0;

   typedef struct {
      tty_pkg::req_type w;
      logic    known;
      tty_pkg::rsp_type r;
   } row_type;

   function automatic void region(output int t, output int b);
      if (top_sh >= SCREEN_ROWS || bot_sh >= SCREEN_ROWS || bot_sh < top_sh) begin
         t = 0;
         b = SCREEN_ROWS - 1;
      end else begin
         t = top_sh;
         b = bot_sh;
      end
   endfunction

   function automatic void blank(int idx);
      if (idx >= 0 && idx < CELLS) begin
         scr_char[idx] = '0;
         scr_pal[idx] = pal_sh;
      end
   endfunction

   function automatic void blank_row(int r);
      for (int c = 0; c < SCREEN_COLS; c++) blank(r * SCREEN_COLS + c);
   endfunction

   function automatic void move_row(int d, int s);
      for (int c = 0; c < SCREEN_COLS; c++) begin
         scr_char[d * SCREEN_COLS + c] = scr_char[s * SCREEN_COLS + c];
         scr_pal[d * SCREEN_COLS + c] = scr_pal[s * SCREEN_COLS + c];
      end
   endfunction

   function automatic void shift_region(int n, bit up);
      int t, b, h;
      region(t, b);
      h = b - t + 1;
      if (n == 0) return;
      if (n > h) n = h;
      if (up) begin
         for (int y = t; y + n <= b; y++) move_row(y, y + n);
         for (int y = b + 1 - n; y <= b; y++) blank_row(y);
      end else begin
         for (int y = b; y >= t + n; y--) move_row(y, y - n);
         for (int y = t; y < t + n; y++) blank_row(y);
      end
   endfunction

   function automatic tty_pkg::rsp_type terminal_step(tty_pkg::req_type w);
      tty_pkg::rsp_type r;
      int t, b;
      r = '0;
      case (w.action)
         tty_pkg::ACT_PUT: begin
            if (w.char_code == tty_pkg::CH_LF) begin
               cur_c = 0;
               cur_r++;
            end else if (w.char_code == tty_pkg::CH_CR) begin
               cur_c = 0;
            end else if (w.char_code == tty_pkg::CH_TAB) begin
               cur_c = (cur_c + 4) & ~3;
            end else if (w.char_code == tty_pkg::CH_BS) begin
               if (cur_c > 0) cur_c--;
            end else begin
               if (cur_c < SCREEN_COLS && cur_r < SCREEN_ROWS) begin
                  scr_char[cur_r * SCREEN_COLS + cur_c] = w.char_code;
                  scr_pal[cur_r * SCREEN_COLS + cur_c] = pal_sh;
               end
               cur_c++;
            end
            if (cur_c >= SCREEN_COLS) begin
               cur_c = 0;
               cur_r++;
            end
            region(t, b);
            if (cur_r > b) begin
               shift_region(1, 1'b1);
               cur_r = b;
               r.scrolled = 1'b1;
            end
         end
         tty_pkg::ACT_SET: begin
            if (w.col < SCREEN_COLS) cur_c = w.col;
            if (w.row < SCREEN_ROWS) cur_r = w.row;
         end
         tty_pkg::ACT_SAVE: begin
            sav_c = cur_c;
            sav_r = cur_r;
         end
         tty_pkg::ACT_RESTORE: begin
            cur_c = sav_c;
            cur_r = sav_r;
         end
         tty_pkg::ACT_CLEAR: begin
            for (int i = 0; i < CELLS; i++) blank(i);
            cur_c = 0;
            cur_r = 0;
         end
         tty_pkg::ACT_CLR_END:
            for (int i = cur_r * SCREEN_COLS + cur_c; i < CELLS; i++) blank(i);
         tty_pkg::ACT_CLR_EOL:
            for (int i = cur_c; i < SCREEN_COLS; i++) blank(cur_r * SCREEN_COLS + i);
         tty_pkg::ACT_SCR_UP: shift_region(w.line_count, 1'b1);
         tty_pkg::ACT_SCR_DN: shift_region(w.line_count, 1'b0);
         tty_pkg::ACT_READ: begin
            if (w.col < SCREEN_COLS && w.row < SCREEN_ROWS) begin
               r.cell_char = scr_char[w.row * SCREEN_COLS + w.col];
               r.cell_palette = scr_pal[w.row * SCREEN_COLS + w.col];
            end
         end
         default: ;
      endcase
      r.cursor_col_out = cur_c[5:0];
      r.cursor_row_out = cur_r[4:0];
      return r;
   endfunction

   // check responses
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected: actual %p", $time, rsp_word);
            errors++;
         end else begin
            tty_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            checked++;
            if (e.scrolled) scrolls_seen++;
            if (rsp_word !== e) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_word);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [4:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tty_pkg::REG_PALETTE: pal_sh = val;
         tty_pkg::REG_TOP:     top_sh = val;
         default:              bot_sh = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold until the block has drained
   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (5000) @(posedge clock);
   endtask

   task automatic send_word(tty_pkg::req_type w, bit known, tty_pkg::rsp_type r, bit quiet);
      tty_pkg::rsp_type p;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      p = terminal_step(w);
      if (known && p !== r) begin
         $display("%0t: table row disagrees expected %p predicted %p", $time, r, p);
         errors++;
      end
      pending_rsp.push_back(p);
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic tty_pkg::req_type rand_word(bit legal_only);
      tty_pkg::req_type w;
      int k;
      w.action = legal_only ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 15));
      k = $urandom_range(0, 99);
      if (k < 55) w.action = tty_pkg::ACT_PUT;
      else if (k < 62) w.action = tty_pkg::ACT_READ;
      w.char_code = 8'($urandom);
      case ($urandom_range(0, 5))
         0: w.char_code = tty_pkg::CH_LF;
         1: w.char_code = tty_pkg::CH_CR;
         2: w.char_code = tty_pkg::CH_TAB;
         3: w.char_code = tty_pkg::CH_BS;
         default: ;
      endcase
      w.col = $urandom_range(0, 4) == 0 ? 6'($urandom) : 6'($urandom_range(0, 39));
      w.row = $urandom_range(0, 4) == 0 ? 5'($urandom) : 5'($urandom_range(0, 24));
      w.line_count = $urandom_range(0, 6) == 0 ? 5'($urandom) : 5'($urandom_range(0, 4));
      if ((w.action == tty_pkg::ACT_CLEAR || w.action == tty_pkg::ACT_CLR_END)
          && $urandom_range(0, 2) != 0)
         w.action = tty_pkg::ACT_READ;
      return w;
   endfunction

   row_type dir_rows [$];

   function automatic row_type mk(logic [3:0] a, logic [7:0] ch, logic [5:0] c,
                                  logic [4:0] r, logic [4:0] n, bit known,
                                  tty_pkg::rsp_type exp_rsp);
      row_type x;
      x.w = '{action: a, char_code: ch, col: c, row: r, line_count: n};
      x.known = known;
      x.r = exp_rsp;
      return x;
   endfunction

   initial begin
      tty_pkg::req_type w;
      for (int i = 0; i < CELLS; i++) begin
         scr_char[i] = '0;
         scr_pal[i] = '0;
      end
      cur_c = 0; cur_r = 0; sav_c = 0; sav_r = 0;
      pal_sh = 0; top_sh = 0; bot_sh = 24;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      dir_rows.push_back(mk(tty_pkg::ACT_READ, 0, 0, 0, 0, 1, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_READ, 0, 39, 24, 0, 1, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_PUT, 8'hff, 0, 0, 0, 1, '{1, 0, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_READ, 0, 0, 0, 0, 1, '{1, 0, 8'hff, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_PUT, tty_pkg::CH_TAB, 0, 0, 0, 1, '{4, 0, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_PUT, tty_pkg::CH_BS, 0, 0, 0, 1, '{3, 0, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_PUT, tty_pkg::CH_CR, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_PUT, tty_pkg::CH_BS, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_PUT, tty_pkg::CH_LF, 0, 0, 0, 1, '{0, 1, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_SET, 0, 63, 31, 0, 1, '{0, 1, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_SET, 0, 39, 24, 0, 1, '{39, 24, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_SAVE, 0, 0, 0, 0, 1, '{39, 24, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_PUT, 8'h41, 0, 0, 0, 1, '{0, 24, 0, 0, 1}));
      dir_rows.push_back(mk(tty_pkg::ACT_READ, 0, 39, 23, 0, 1, '{0, 24, 8'h41, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_RESTORE, 0, 0, 0, 0, 1, '{39, 24, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_READ, 0, 63, 31, 0, 1, '{39, 24, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_SET, 0, 5, 10, 0, 0, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_CLR_EOL, 0, 0, 0, 0, 0, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_SCR_DN, 0, 0, 0, 3, 0, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_SCR_UP, 0, 0, 0, 31, 0, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_SCR_UP, 0, 0, 0, 0, 0, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_CLR_END, 0, 0, 0, 0, 0, '0));
      dir_rows.push_back(mk(4'd15, 0, 0, 0, 0, 1, '{5, 10, 0, 0, 0}));
      dir_rows.push_back(mk(tty_pkg::ACT_CLEAR, 0, 0, 0, 0, 1, '0));
      dir_rows.push_back(mk(tty_pkg::ACT_READ, 0, 7, 7, 0, 1, '0));
      foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].r, 0);
      drain();

      // random phases over several register settings, extremes included
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               write_reg(tty_pkg::REG_PALETTE, 31);
               write_reg(tty_pkg::REG_TOP, 0);
               write_reg(tty_pkg::REG_BOTTOM, 24);
            end
            1: begin
               write_reg(tty_pkg::REG_PALETTE, 5);
               write_reg(tty_pkg::REG_TOP, 3);
               write_reg(tty_pkg::REG_BOTTOM, 9);
            end
            2: begin
               write_reg(tty_pkg::REG_PALETTE, 0);
               write_reg(tty_pkg::REG_TOP, 24);
               write_reg(tty_pkg::REG_BOTTOM, 24);
            end
            3: begin
               write_reg(tty_pkg::REG_TOP, 12);
               write_reg(tty_pkg::REG_BOTTOM, 4);
            end
            4: begin
               write_reg(tty_pkg::REG_PALETTE, 17);
               write_reg(tty_pkg::REG_TOP, 31);
               write_reg(tty_pkg::REG_BOTTOM, 31);
            end
            5: begin
               write_reg(tty_pkg::REG_PALETTE, 10);
               write_reg(tty_pkg::REG_TOP, 0);
               write_reg(tty_pkg::REG_BOTTOM, 0);
            end
            default: begin
               write_reg(2'($urandom_range(0, 2)), 5'($urandom));
               write_reg(tty_pkg::REG_TOP, 5'($urandom_range(0, 24)));
               write_reg(tty_pkg::REG_BOTTOM, 5'($urandom_range(0, 24)));
            end
         endcase
         for (int i = 0; i < 100; i++) begin
            w = rand_word(i % 10 != 0);
            send_word(w, 0, '0, ph == 6 && i >= 60);
         end
         drain();
      end

      $display("Ran %0d responses, %0d region scrolls from put char,", checked, scrolls_seen);
      $display("over seven palette and scroll region settings plus directed cases.");
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
